@@ design/aci_pkg.sv @@
// ----------------------------------------------------------------------------
// aci_pkg
// Shared types, constants and arithmetic helpers of the antiperiodic cubic
// interpolator.
// ----------------------------------------------------------------------------
package aci_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned TAU_W     = 32;
  localparam int unsigned LINE_W    = 4;
  localparam int unsigned SLICE_W   = 6;
  localparam int unsigned SEL_W     = 2;
  localparam int unsigned UT_W      = 31;
  localparam int unsigned SCALED_W  = 62;
  localparam int unsigned FRAC_W    = 32;
  localparam int unsigned D_W       = 33;
  localparam int unsigned PROD_W    = 66;
  localparam int unsigned NUM_COEFS = 4;
  localparam int unsigned ADDR_W_CFG = 3;

  localparam logic [CFG_W-1:0] BETA_RESET = 31'd655360;
  localparam logic [CFG_W-1:0] SPB_RESET  = 31'd419430;

  localparam logic REG_BETA = 1'b0;
  localparam logic REG_SPB  = 1'b1;

  localparam logic [D_W-1:0] D_ONE = {1'b1, {FRAC_W{1'b0}}};

  localparam logic signed [PROD_W-1:0] ROUND_HALF =
    {{(PROD_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] SAT_HI =
    {{(PROD_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_LO =
    {{(PROD_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_EVAL       = 2'd0,
    CMD_LOAD_COEFF = 2'd1,
    CMD_LOAD_ZERO  = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] beta;
    logic [CFG_W-1:0] spb;
  } cfg_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [LINE_W-1:0]  line;
    logic [SLICE_W-1:0] slice;
    logic [SEL_W-1:0]   sel;
    logic [WORD_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic              valid;
    logic              is_eval;
    logic              err;
    logic              neg;
    logic              zero;
    logic              line_ok;
    logic [WORD_W-1:0] zval;
  } meta_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] c3;
    logic signed [WORD_W-1:0] c2;
    logic signed [WORD_W-1:0] c1;
    logic signed [WORD_W-1:0] c0;
  } coefs_t;

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] r;
    r = v;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end
    return r[WORD_W-1:0];
  endfunction

endpackage

@@ design/aci_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// aci_cfg_regs
// Configuration registers behind the APB-style port: beta and slices per beta.
// ----------------------------------------------------------------------------
module aci_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [aci_pkg::ADDR_W_CFG-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output aci_pkg::cfg_t                  cfg
);

  logic [aci_pkg::CFG_W-1:0] beta_r;
  logic [aci_pkg::CFG_W-1:0] spb_r;
  logic                      reg_idx;
  logic                      wr_en;

  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r <= aci_pkg::BETA_RESET;
      spb_r  <= aci_pkg::SPB_RESET;
    end else if (wr_en) begin
      if (reg_idx == aci_pkg::REG_BETA) begin
        beta_r <= pwdata[aci_pkg::CFG_W-1:0];
      end else begin
        spb_r <= pwdata[aci_pkg::CFG_W-1:0];
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      aci_pkg::REG_BETA: prdata = {1'b0, beta_r};
      aci_pkg::REG_SPB:  prdata = {1'b0, spb_r};
      default:           prdata = '0;
    endcase
  end

  assign cfg.beta = beta_r;
  assign cfg.spb  = spb_r;

endmodule

@@ design/aci_front.sv @@
// ----------------------------------------------------------------------------
// aci_front
// Front stages: request capture, range check with antiperiodic shift, and
// scaling of tau by slices per beta.
// ----------------------------------------------------------------------------
module aci_front #(
  parameter int unsigned NUM_LINES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_fire,
  input  aci_pkg::req_t                    in_req,
  input  logic [aci_pkg::TAU_W-1:0]        in_tau,
  input  aci_pkg::cfg_t                    cfg,
  output aci_pkg::meta_t                   f2_meta,
  output aci_pkg::req_t                    f2_req,
  output logic [aci_pkg::SCALED_W-1:0]     f2_scaled
);

  logic                          f0_valid_r;
  aci_pkg::req_t                 f0_req_r;
  logic [aci_pkg::TAU_W-1:0]     f0_tau_r;

  aci_pkg::meta_t                f1_meta_r;
  aci_pkg::meta_t                f1_meta_nxt;
  aci_pkg::req_t                 f1_req_r;
  logic [aci_pkg::UT_W-1:0]      f1_ut_r;
  logic [aci_pkg::UT_W-1:0]      f1_ut_nxt;

  aci_pkg::meta_t                f2_meta_r;
  aci_pkg::req_t                 f2_req_r;
  logic [aci_pkg::SCALED_W-1:0]  f2_scaled_r;
  logic [aci_pkg::SCALED_W-1:0]  f2_scaled_nxt;

  logic signed [aci_pkg::TAU_W:0] t_ext;
  logic signed [aci_pkg::TAU_W:0] b_ext;
  logic signed [aci_pkg::TAU_W:0] shifted;

  always_comb begin
    t_ext   = {f0_tau_r[aci_pkg::TAU_W-1], f0_tau_r};
    b_ext   = {2'b00, cfg.beta};
    shifted = t_ext + b_ext;

    f1_meta_nxt         = '0;
    f1_meta_nxt.valid   = f0_valid_r;
    f1_meta_nxt.is_eval = (f0_req_r.cmd == aci_pkg::CMD_EVAL);
    f1_meta_nxt.err     = (t_ext > b_ext) || (t_ext < -b_ext);
    f1_meta_nxt.neg     = f0_tau_r[aci_pkg::TAU_W-1];
    f1_meta_nxt.zero    = (f0_tau_r == '0);
    f1_meta_nxt.line_ok = (32'(f0_req_r.line) < 32'(NUM_LINES));
    f1_ut_nxt = f1_meta_nxt.neg ? shifted[aci_pkg::UT_W-1:0]
                                : f0_tau_r[aci_pkg::UT_W-1:0];
  end

  assign f2_scaled_nxt = f1_ut_r * cfg.spb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_valid_r      <= 1'b0;
      f1_meta_r.valid <= 1'b0;
      f2_meta_r.valid <= 1'b0;
    end else if (en) begin
      f0_valid_r  <= in_fire;
      f0_req_r    <= in_req;
      f0_tau_r    <= in_tau;
      f1_meta_r   <= f1_meta_nxt;
      f1_req_r    <= f0_req_r;
      f1_ut_r     <= f1_ut_nxt;
      f2_meta_r   <= f1_meta_r;
      f2_req_r    <= f1_req_r;
      f2_scaled_r <= f2_scaled_nxt;
    end
  end

  assign f2_meta   = f2_meta_r;
  assign f2_req    = f2_req_r;
  assign f2_scaled = f2_scaled_r;

endmodule

@@ design/aci_table.sv @@
// ----------------------------------------------------------------------------
// aci_table
// Slice selection and the coefficient and zero-value memories. Loads write and
// evaluations read in this one stage, so requests keep their order.
// ----------------------------------------------------------------------------
module aci_table #(
  parameter int unsigned NUM_SLICES = 64,
  parameter int unsigned NUM_LINES  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  aci_pkg::meta_t                f2_meta,
  input  aci_pkg::req_t                 f2_req,
  input  logic [aci_pkg::SCALED_W-1:0]  f2_scaled,
  output aci_pkg::meta_t                t_meta,
  output logic [aci_pkg::D_W-1:0]       t_d,
  output aci_pkg::coefs_t               t_coefs
);

  localparam int unsigned DEPTH   = NUM_LINES * NUM_SLICES;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LINE_AW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

  logic [aci_pkg::WORD_W-1:0] coef_mem [aci_pkg::NUM_COEFS][DEPTH];
  logic [aci_pkg::WORD_W-1:0] zero_mem [NUM_LINES];

  aci_pkg::meta_t             t_meta_r;
  logic [aci_pkg::D_W-1:0]    t_d_r;
  logic [aci_pkg::D_W-1:0]    t_d_nxt;
  logic [aci_pkg::WORD_W-1:0] t_c_r [aci_pkg::NUM_COEFS];
  logic [aci_pkg::WORD_W-1:0] t_zval_r;

  logic [31:0]         idx_full;
  logic [31:0]         slot;
  logic [31:0]         addr_full;
  logic [31:0]         line_full;
  logic [ADDR_W-1:0]   addr;
  logic [LINE_AW-1:0]  zaddr;
  logic                over;
  logic                slice_ok;
  logic                coef_we;
  logic                zero_we;

  always_comb begin
    idx_full  = 32'(f2_scaled[aci_pkg::SCALED_W-1:aci_pkg::FRAC_W]);
    over      = (idx_full >= 32'(NUM_SLICES));
    t_d_nxt   = over ? aci_pkg::D_ONE : {1'b0, f2_scaled[aci_pkg::FRAC_W-1:0]};
    slice_ok  = (32'(f2_req.slice) < 32'(NUM_SLICES));
    if (f2_req.cmd == aci_pkg::CMD_LOAD_COEFF) begin
      slot = 32'(f2_req.slice);
    end else if (over) begin
      slot = 32'(NUM_SLICES - 1);
    end else begin
      slot = idx_full;
    end
    line_full = 32'(f2_req.line);
    addr_full = line_full * 32'(NUM_SLICES) + slot;
    addr      = addr_full[ADDR_W-1:0];
    zaddr     = line_full[LINE_AW-1:0];
    coef_we   = en && f2_meta.valid && f2_meta.line_ok && slice_ok &&
                (f2_req.cmd == aci_pkg::CMD_LOAD_COEFF);
    zero_we   = en && f2_meta.valid && f2_meta.line_ok &&
                (f2_req.cmd == aci_pkg::CMD_LOAD_ZERO);
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < aci_pkg::NUM_COEFS; b++) begin
      if (coef_we && (32'(f2_req.sel) == 32'(b))) begin
        coef_mem[b][addr] <= f2_req.value;
      end
      if (en) begin
        t_c_r[b] <= coef_mem[b][addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (zero_we) begin
      zero_mem[zaddr] <= f2_req.value;
    end
    if (en) begin
      t_zval_r <= zero_mem[zaddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_meta_r.valid <= 1'b0;
    end else if (en) begin
      t_meta_r <= f2_meta;
      t_d_r    <= t_d_nxt;
    end
  end

  always_comb begin
    t_meta      = t_meta_r;
    t_meta.zval = t_zval_r;
  end

  assign t_d        = t_d_r;
  assign t_coefs.c0 = t_c_r[0];
  assign t_coefs.c1 = t_c_r[1];
  assign t_coefs.c2 = t_c_r[2];
  assign t_coefs.c3 = t_c_r[3];

endmodule

@@ design/aci_horner_step.sv @@
// ----------------------------------------------------------------------------
// aci_horner_step
// One Horner step over two stages: the product of accumulator and fraction,
// then rounding, the coefficient add and saturation.
// ----------------------------------------------------------------------------
module aci_horner_step (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  aci_pkg::meta_t                     meta_in,
  input  logic signed [aci_pkg::WORD_W-1:0]  acc_in,
  input  logic signed [aci_pkg::WORD_W-1:0]  coef_add,
  input  logic [aci_pkg::D_W-1:0]            d_in,
  input  aci_pkg::coefs_t                    coefs_in,
  output aci_pkg::meta_t                     meta_out,
  output logic signed [aci_pkg::WORD_W-1:0]  acc_out,
  output logic [aci_pkg::D_W-1:0]            d_out,
  output aci_pkg::coefs_t                    coefs_out
);

  aci_pkg::meta_t                     m_meta_r;
  logic signed [aci_pkg::PROD_W-1:0]  m_prod_r;
  logic signed [aci_pkg::PROD_W-1:0]  m_prod_nxt;
  logic signed [aci_pkg::WORD_W-1:0]  m_coef_r;
  logic [aci_pkg::D_W-1:0]            m_d_r;
  aci_pkg::coefs_t                    m_coefs_r;

  aci_pkg::meta_t                     a_meta_r;
  logic signed [aci_pkg::WORD_W-1:0]  a_acc_r;
  logic signed [aci_pkg::WORD_W-1:0]  a_acc_nxt;
  logic [aci_pkg::D_W-1:0]            a_d_r;
  aci_pkg::coefs_t                    a_coefs_r;

  logic signed [aci_pkg::D_W:0]       d_signed;
  logic signed [aci_pkg::PROD_W-1:0]  rounded;
  logic signed [aci_pkg::PROD_W-1:0]  total;

  assign d_signed   = $signed({1'b0, d_in});
  assign m_prod_nxt = acc_in * d_signed;

  always_comb begin
    rounded   = (m_prod_r + aci_pkg::ROUND_HALF) >>> aci_pkg::FRAC_W;
    total     = rounded + aci_pkg::PROD_W'(m_coef_r);
    a_acc_nxt = aci_pkg::sat_word(total);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_meta_r.valid <= 1'b0;
      a_meta_r.valid <= 1'b0;
    end else if (en) begin
      m_meta_r  <= meta_in;
      m_prod_r  <= m_prod_nxt;
      m_coef_r  <= coef_add;
      m_d_r     <= d_in;
      m_coefs_r <= coefs_in;
      a_meta_r  <= m_meta_r;
      a_acc_r   <= a_acc_nxt;
      a_d_r     <= m_d_r;
      a_coefs_r <= m_coefs_r;
    end
  end

  assign meta_out  = a_meta_r;
  assign acc_out   = a_acc_r;
  assign d_out     = a_d_r;
  assign coefs_out = a_coefs_r;

endmodule

@@ design/antiperiodic_cubic_interpolator_unit.sv @@
// ----------------------------------------------------------------------------
// antiperiodic_cubic_interpolator_unit
// Piecewise cubic lookup of an antiperiodic function of tau, with coefficient
// and zero-value loading and an APB-style configuration port.
//
//   Channel  Direction  Handshake              Carries
//   in       input      in_valid / in_ready    command, tau, line, slice, load
//   out      output     out_valid / out_ready  result, range_error
//   cfg      input      psel / penable / pwrite beta, slices per beta
//
// One request is taken every cycle while no result is held. An evaluation
// passes eleven registers (three front stages, the table stage, six Horner
// stages and the output register), the first of which loads at the accepting
// edge. The three Horner multipliers set the depth.
// Reset clears all valid bits; the tables are undefined until loaded.
// A held result stalls every stage together, so in_ready falls with it.
// ----------------------------------------------------------------------------
module antiperiodic_cubic_interpolator_unit #(
  parameter int unsigned NUM_SLICES = 64,
  parameter int unsigned NUM_LINES  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_command,
  input  logic signed [31:0]              in_tau,
  input  logic [3:0]                      in_line_index,
  input  logic [5:0]                      in_slice_index,
  input  logic [1:0]                      in_coeff_select,
  input  logic signed [31:0]              in_load_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [31:0]              out_result,
  output logic                            out_range_error,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [aci_pkg::ADDR_W_CFG-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  aci_pkg::cfg_t    cfg;
  aci_pkg::req_t    in_req;
  logic             en;
  logic             in_fire;

  aci_pkg::meta_t                    f2_meta;
  aci_pkg::req_t                     f2_req;
  logic [aci_pkg::SCALED_W-1:0]      f2_scaled;

  aci_pkg::meta_t                    t_meta;
  logic [aci_pkg::D_W-1:0]           t_d;
  aci_pkg::coefs_t                   t_coefs;

  aci_pkg::meta_t                    h1_meta, h2_meta, h3_meta;
  logic signed [aci_pkg::WORD_W-1:0] h1_acc, h2_acc, h3_acc;
  logic [aci_pkg::D_W-1:0]           h1_d, h2_d, h3_d;
  aci_pkg::coefs_t                   h1_coefs, h2_coefs, h3_coefs;

  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic signed [aci_pkg::WORD_W-1:0] out_result_r;
  logic signed [aci_pkg::WORD_W-1:0] out_result_nxt;
  logic                              out_range_error_r;
  logic signed [aci_pkg::PROD_W-1:0] neg_acc;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    in_req.cmd   = aci_pkg::cmd_t'(in_command);
    in_req.line  = in_line_index;
    in_req.slice = in_slice_index;
    in_req.sel   = in_coeff_select;
    in_req.value = in_load_value;
  end

  aci_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aci_front #(
    .NUM_LINES (NUM_LINES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_fire   (in_fire),
    .in_req    (in_req),
    .in_tau    (in_tau),
    .cfg       (cfg),
    .f2_meta   (f2_meta),
    .f2_req    (f2_req),
    .f2_scaled (f2_scaled)
  );

  aci_table #(
    .NUM_SLICES (NUM_SLICES),
    .NUM_LINES  (NUM_LINES)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .f2_meta   (f2_meta),
    .f2_req    (f2_req),
    .f2_scaled (f2_scaled),
    .t_meta    (t_meta),
    .t_d       (t_d),
    .t_coefs   (t_coefs)
  );

  aci_horner_step u_step1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .meta_in   (t_meta),
    .acc_in    (t_coefs.c3),
    .coef_add  (t_coefs.c2),
    .d_in      (t_d),
    .coefs_in  (t_coefs),
    .meta_out  (h1_meta),
    .acc_out   (h1_acc),
    .d_out     (h1_d),
    .coefs_out (h1_coefs)
  );

  aci_horner_step u_step2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .meta_in   (h1_meta),
    .acc_in    (h1_acc),
    .coef_add  (h1_coefs.c1),
    .d_in      (h1_d),
    .coefs_in  (h1_coefs),
    .meta_out  (h2_meta),
    .acc_out   (h2_acc),
    .d_out     (h2_d),
    .coefs_out (h2_coefs)
  );

  aci_horner_step u_step3 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .meta_in   (h2_meta),
    .acc_in    (h2_acc),
    .coef_add  (h2_coefs.c0),
    .d_in      (h2_d),
    .coefs_in  (h2_coefs),
    .meta_out  (h3_meta),
    .acc_out   (h3_acc),
    .d_out     (h3_d),
    .coefs_out (h3_coefs)
  );

  always_comb begin
    neg_acc       = -aci_pkg::PROD_W'(h3_acc);
    out_valid_nxt = h3_meta.valid && h3_meta.is_eval;
    if (h3_meta.err || !h3_meta.line_ok) begin
      out_result_nxt = '0;
    end else if (h3_meta.zero) begin
      out_result_nxt = h3_meta.zval;
    end else if (h3_meta.neg) begin
      out_result_nxt = aci_pkg::sat_word(neg_acc);
    end else begin
      out_result_nxt = h3_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r       <= out_valid_nxt;
      out_result_r      <= out_result_nxt;
      out_range_error_r <= h3_meta.err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result      = out_result_r;
  assign out_range_error = out_range_error_r;

endmodule

@@ design/aci_checker.sv @@
// ----------------------------------------------------------------------------
// aci_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module aci_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_result,
  input logic               out_range_error,
  input logic               pready
);

  // A result that is waiting must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) &&
    $stable(out_range_error))
    else $error("result changed while stalled");

  // An out-of-range tau always reports a zero result.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_result == 32'sd0)
    else $error("range error with non-zero result");

  // The whole pipeline stalls behind a held result.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request accepted while the pipeline is stalled");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("configuration port not ready");

endmodule

bind antiperiodic_cubic_interpolator_unit aci_checker u_aci_checker (.*);

@@ sim/antiperiodic_cubic_interpolator_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// antiperiodic_cubic_interpolator_unit_tb
// Self-checking bench for the antiperiodic cubic interpolator. The tables of
// three lines are filled first, then directed and random requests run under
// several settings of beta and slices per beta. A scoreboard predicts each
// evaluation and compares the returned value and range flag in order. Both
// handshakes see random idle cycles, apart from one long stretch that runs at
// full rate.
// ----------------------------------------------------------------------------

typedef struct {
  aci_pkg::cmd_t      cmd;
  logic signed [31:0] tau;
  logic [3:0]         line;
  logic [5:0]         slice;
  logic [1:0]         sel;
  logic signed [31:0] value;
} request_t;

typedef struct {
  logic signed [31:0] result;
  logic               range_error;
} lookup_t;

class interpolator_scoreboard;
  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned LINE_COUNT  = 16;
  localparam int unsigned SLICE_COUNT = 64;
  localparam logic signed [95:0] WIDE_MAX = 96'sd2147483647;
  localparam logic signed [95:0] WIDE_MIN = -96'sd2147483648;
  localparam logic signed [95:0] HALF_LSB = 96'sd2147483648;

  logic [30:0]        beta_q;
  logic [30:0]        spb_q;
  logic signed [31:0] coef_mem [TABLE_DEPTH];
  logic signed [31:0] zero_mem [LINE_COUNT];
  lookup_t            lookups_due [$];
  int                 mismatches;

  function new();
    beta_q = aci_pkg::BETA_RESET;
    spb_q = aci_pkg::SPB_RESET;
    mismatches = 0;
  endfunction

  task report_mismatch(input string what);
    $display("%0t ERROR: %s", $realtime, what);
    mismatches++;
  endtask

  function logic signed [31:0] horner_step(input logic signed [31:0] acc,
                                           input logic signed [31:0] c,
                                           input logic [aci_pkg::D_W-1:0] d);
    logic signed [95:0] a_w;
    logic signed [95:0] d_w;
    logic signed [95:0] c_w;
    logic signed [95:0] sum;
    a_w = acc;
    d_w = {63'd0, d};
    c_w = c;
    sum = c_w + ((a_w * d_w + HALF_LSB) >>> 32);
    if (sum > WIDE_MAX) begin
      return 32'sh7fff_ffff;
    end else if (sum < WIDE_MIN) begin
      return 32'sh8000_0000;
    end
    return sum[31:0];
  endfunction

  function void note_request(input request_t r);
    lookup_t                   e;
    longint                    b;
    longint                    t;
    longint                    ut;
    logic [63:0]               scaled;
    logic [aci_pkg::D_W-1:0]   d;
    logic [5:0]                slot;
    logic [11:0]               base;
    logic signed [31:0]        acc;
    case (r.cmd)
      aci_pkg::CMD_LOAD_COEFF: begin
        coef_mem[{r.line, r.slice, r.sel}] = r.value;
      end
      aci_pkg::CMD_LOAD_ZERO: begin
        zero_mem[r.line] = r.value;
      end
      aci_pkg::CMD_EVAL: begin
        b = longint'(beta_q);
        t = longint'(r.tau);
        e.result = '0;
        e.range_error = 1'b0;
        if (t < -b || t > b) begin
          e.range_error = 1'b1;
        end else if (t == 0) begin
          e.result = zero_mem[r.line];
        end else begin
          // Negative tau is folded into the positive half and negated.
          ut = (t < 0) ? t + b : t;
          scaled = ut * longint'(spb_q);
          d = {1'b0, scaled[31:0]};
          slot = scaled[37:32];
          if (scaled[63:32] >= SLICE_COUNT) begin
            slot = 6'd63;
            d = aci_pkg::D_ONE;
          end
          base = {r.line, slot, 2'b00};
          acc = coef_mem[base + 12'd3];
          acc = horner_step(acc, coef_mem[base + 12'd2], d);
          acc = horner_step(acc, coef_mem[base + 12'd1], d);
          acc = horner_step(acc, coef_mem[base], d);
          if (t < 0) begin
            acc = (acc == 32'sh8000_0000) ? 32'sh7fff_ffff : -acc;
          end
          e.result = acc;
        end
        lookups_due.push_back(e);
      end
      default: begin
      end
    endcase
  endfunction

  task check_result(input logic signed [31:0] result, input logic range_error);
    lookup_t e;
    if (lookups_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", result));
    end else begin
      e = lookups_due.pop_front();
      if (result !== e.result) begin
        report_mismatch($sformatf("result %h, predicted %h", result, e.result));
      end
      if (range_error !== e.range_error) begin
        report_mismatch($sformatf("range_error %b, predicted %b", range_error,
                                  e.range_error));
      end
    end
  endtask
endclass

module antiperiodic_cubic_interpolator_unit_tb;

  localparam int unsigned NUM_SLICES   = 64;
  localparam int unsigned NUM_LINES    = 16;
  localparam int unsigned FILLED_COUNT = 3;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam logic [aci_pkg::ADDR_W_CFG-1:0] ADDR_BETA = {aci_pkg::REG_BETA, 2'b00};
  localparam logic [aci_pkg::ADDR_W_CFG-1:0] ADDR_SPB  = {aci_pkg::REG_SPB, 2'b00};

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [1:0]                     in_command = aci_pkg::CMD_NONE;
  logic signed [31:0]             in_tau = '0;
  logic [3:0]                     in_line_index = '0;
  logic [5:0]                     in_slice_index = '0;
  logic [1:0]                     in_coeff_select = '0;
  logic signed [31:0]             in_load_value = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic signed [31:0]             out_result;
  logic                           out_range_error;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [aci_pkg::ADDR_W_CFG-1:0] paddr = '0;
  logic [31:0]                    pwdata = '0;
  logic [31:0]                    prdata;
  logic                           pready;

  bit                     gaps_on = 1'b1;
  interpolator_scoreboard sb;

  antiperiodic_cubic_interpolator_unit #(
    .NUM_SLICES(NUM_SLICES),
    .NUM_LINES (NUM_LINES)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_tau         (in_tau),
    .in_line_index  (in_line_index),
    .in_slice_index (in_slice_index),
    .in_coeff_select(in_coeff_select),
    .in_load_value  (in_load_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result     (out_result),
    .out_range_error(out_range_error),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    if (gaps_on) begin
      out_ready <= ($urandom_range(99) >= 21);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_result, out_range_error);
    end
  end

  // Lines whose tables are filled completely; evaluations address only these.
  function automatic logic [3:0] filled_line(input int unsigned n);
    case (n)
      0: return 4'd0;
      1: return 4'd5;
      default: return 4'd15;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_word();
    logic [31:0] rnd;
    rnd = $urandom;
    case ($urandom_range(9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3, 4, 5, 6: return $signed({{7{rnd[24]}}, rnd[24:0]});
      default: return $signed(rnd);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_tau();
    longint      b;
    longint      v;
    logic [31:0] rnd;
    b = longint'(sb.beta_q);
    rnd = $urandom;
    case ($urandom_range(19))
      0: v = 0;
      1: v = b;
      2: v = -b;
      3: v = b + 1;
      4: v = -b - 1;
      5: v = longint'(rnd[1:0]) + 1;
      6: v = -longint'(rnd[1:0]) - 1;
      7, 8: v = longint'($signed(rnd));
      default: v = longint'($urandom_range(32'(2 * b))) - b;
    endcase
    return v[31:0];
  endfunction

  function automatic request_t make_request();
    request_t    r;
    logic [31:0] rnd;
    int unsigned p;
    rnd = $urandom;
    r.tau = $signed($urandom);
    r.line = rnd[3:0];
    r.slice = rnd[9:4];
    r.sel = rnd[11:10];
    r.value = $signed($urandom);
    p = $urandom_range(99);
    if (p < 60) begin
      r.cmd = aci_pkg::CMD_EVAL;
      r.tau = pick_tau();
      r.line = filled_line($urandom_range(FILLED_COUNT - 1));
    end else if (p < 88) begin
      r.cmd = aci_pkg::CMD_LOAD_COEFF;
      r.value = pick_word();
    end else if (p < 95) begin
      r.cmd = aci_pkg::CMD_LOAD_ZERO;
      r.value = pick_word();
    end else begin
      r.cmd = aci_pkg::CMD_NONE;
    end
    return r;
  endfunction

  // Entered and left at a falling edge; valid stays high between back-to-back requests.
  task automatic send_request(input request_t r);
    if (gaps_on) begin
      while ($urandom_range(99) < 21) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_command <= r.cmd;
    in_tau <= r.tau;
    in_line_index <= r.line;
    in_slice_index <= r.slice;
    in_coeff_select <= r.sel;
    in_load_value <= r.value;
    do begin
      @(posedge clk);
    end while (!in_ready);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic send_fields(input aci_pkg::cmd_t cmd, input logic signed [31:0] tau,
                             input logic [3:0] line, input logic [5:0] slice,
                             input logic [1:0] sel, input logic signed [31:0] value);
    request_t r;
    r.cmd = cmd;
    r.tau = tau;
    r.line = line;
    r.slice = slice;
    r.sel = sel;
    r.value = value;
    send_request(r);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) begin
      send_request(make_request());
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.lookups_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Entered and left at a falling edge with the port selected; configure releases it.
  task automatic write_reg(input logic [aci_pkg::ADDR_W_CFG-1:0] addr,
                           input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    if (addr == ADDR_BETA) begin
      sb.beta_q = data[30:0];
    end else begin
      sb.spb_q = data[30:0];
    end
    @(negedge clk);
  endtask

  task automatic configure(input logic [30:0] beta, input logic [30:0] spb);
    write_reg(ADDR_BETA, {1'b0, beta});
    write_reg(ADDR_SPB, {1'b0, spb});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    request_t    r;
    longint      q;
    logic [30:0] b;
    sb = new();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every entry of the filled lines is written before any evaluation reads it.
    for (int n = 0; n < FILLED_COUNT; n++) begin
      for (int s = 0; s < NUM_SLICES; s++) begin
        for (int k = 0; k < aci_pkg::NUM_COEFS; k++) begin
          r = make_request();
          r.cmd = aci_pkg::CMD_LOAD_COEFF;
          r.line = filled_line(n);
          r.slice = 6'(s);
          r.sel = 2'(k);
          r.value = pick_word();
          send_request(r);
        end
      end
      send_fields(aci_pkg::CMD_LOAD_ZERO, '0, filled_line(n), '0, '0, pick_word());
    end
    run_random(100);

    settle();
    configure(31'd524288, 31'd524288);
    gaps_on = 1'b0;
    send_fields(aci_pkg::CMD_LOAD_COEFF, '0, 4'd5, 6'd0, 2'd3, 32'sh7fff_ffff);
    send_fields(aci_pkg::CMD_LOAD_COEFF, '0, 4'd5, 6'd0, 2'd2, 32'sh7fff_ffff);
    send_fields(aci_pkg::CMD_LOAD_COEFF, '0, 4'd5, 6'd0, 2'd1, 32'sh7fff_ffff);
    send_fields(aci_pkg::CMD_LOAD_COEFF, '0, 4'd5, 6'd0, 2'd0, 32'sh8000_0000);
    send_fields(aci_pkg::CMD_LOAD_COEFF, '0, 4'd5, 6'd63, 2'd3, 32'sh8000_0000);
    send_fields(aci_pkg::CMD_LOAD_COEFF, '0, 4'd5, 6'd63, 2'd2, 32'sh8000_0000);
    send_fields(aci_pkg::CMD_LOAD_COEFF, '0, 4'd5, 6'd63, 2'd1, 32'sh8000_0000);
    send_fields(aci_pkg::CMD_LOAD_COEFF, '0, 4'd5, 6'd63, 2'd0, 32'sh8000_0000);
    send_fields(aci_pkg::CMD_LOAD_ZERO, '0, 4'd5, 6'd63, 2'd3, 32'sh8000_0000);
    send_fields(aci_pkg::CMD_LOAD_ZERO, '1, 4'd15, 6'd0, 2'd0, 32'sh7fff_ffff);
    send_fields(aci_pkg::CMD_EVAL, '0, 4'd5, 6'd63, 2'd3, '1);
    send_fields(aci_pkg::CMD_EVAL, '0, 4'd15, '0, '0, '0);
    send_fields(aci_pkg::CMD_EVAL, 32'sd524288, 4'd5, '0, '0, '0);
    send_fields(aci_pkg::CMD_EVAL, -32'sd524288, 4'd5, '0, '0, '0);
    send_fields(aci_pkg::CMD_EVAL, -32'sd524287, 4'd5, '0, '0, '0);
    send_fields(aci_pkg::CMD_EVAL, 32'sd1, 4'd5, '0, '0, '0);
    send_fields(aci_pkg::CMD_EVAL, -32'sd1, 4'd5, '0, '0, '0);
    send_fields(aci_pkg::CMD_EVAL, 32'sd524289, 4'd5, '0, '0, '0);
    send_fields(aci_pkg::CMD_EVAL, -32'sd524289, 4'd5, '0, '0, '0);
    send_fields(aci_pkg::CMD_EVAL, 32'sh7fff_ffff, 4'd0, '1, '1, '1);
    send_fields(aci_pkg::CMD_EVAL, 32'sh8000_0000, 4'd15, '0, '0, '0);
    send_fields(aci_pkg::CMD_NONE, '1, 4'd5, 6'd0, 2'd0, '1);
    send_fields(aci_pkg::CMD_EVAL, 32'sd524287, 4'd15, '0, '0, '0);
    run_random(80);
    gaps_on = 1'b1;

    settle();
    configure(31'h7fff_ffff, 31'h7fff_ffff);
    run_random(80);

    settle();
    configure(31'd1, 31'd1);
    run_random(60);

    settle();
    configure(31'h7fff_ffff, 31'd128);
    run_random(80);

    repeat (2) begin
      settle();
      b = 31'($urandom_range(32'h0001_0000, 32'h0040_0000));
      q = (longint'(64) <<< 32) / longint'(b);
      q = q - q / 8 + longint'($urandom_range(32'(q / 4)));
      if (q > 64'sh7fff_ffff) begin
        q = 64'sh7fff_ffff;
      end
      configure(b, q[30:0]);
      run_random(50);
    end

    settle();
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
design/aci_pkg.sv
design/aci_cfg_regs.sv
design/aci_front.sv
design/aci_table.sv
design/aci_horner_step.sv
design/antiperiodic_cubic_interpolator_unit.sv
design/aci_checker.sv
sim/antiperiodic_cubic_interpolator_unit_tb.sv
